[hw/rtl/ptd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared widths, constants and types of the point to triangle distance block.
// ----------------------------------------------------------------------------
package ptd_pkg;

    localparam int COORD_BITS = 24;
    localparam int PAR_BITS   = 32;
    localparam int OUT_BITS   = COORD_BITS + 1;

    localparam int DW   = COORD_BITS + 1;
    localparam int PRW  = 2 * DW;
    localparam int DOTW = PRW + 2;
    localparam int MW   = 2 * COORD_BITS + 2;
    localparam int HW   = MW / 2;
    localparam int WW   = 2 * MW + 4;

    localparam int QW = PAR_BITS + 1;
    localparam logic [QW-1:0] PAR_ONE = QW'(1) << PAR_BITS;

    localparam int VW        = DW + PAR_BITS + 3;
    localparam int VMW       = VW - 2;
    localparam int VHW       = VMW / 2;
    localparam int SQW       = 2 * VMW + 2;
    localparam int ROOT_BITS = (SQW - 2 * PAR_BITS) / 2;
    localparam int RMW       = ROOT_BITS + 3;

    localparam int IN_TDW  = 12 * COORD_BITS;
    localparam int OUT_TDW = ((OUT_BITS + 1 + 7) / 8) * 8;

    typedef logic [2:0][DW-1:0] vec3_t;

    typedef struct packed {
        vec3_t e0;
        vec3_t e1;
        vec3_t dv;
    } geom_t;

    typedef enum logic [1:0] {
        Q_ZERO,
        Q_ONE,
        Q_DIV
    } qsel_t;

    typedef struct packed {
        qsel_t          sel;
        logic [WW-1:0]  num;
        logic [WW-1:0]  den;
    } lane_t;

    typedef struct packed {
        geom_t geo;
        logic  comp_s;
        logic  comp_t;
        logic  flag;
    } side_t;

endpackage

[hw/rtl/ptd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_front
// Edge vectors, dot products, s, t and det, region choice and divider setup.
// ----------------------------------------------------------------------------
module ptd_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [ptd_pkg::IN_TDW-1:0]        in_data,
    output logic                              out_valid,
    output ptd_pkg::lane_t [1:0]              out_lanes,
    output ptd_pkg::side_t                    out_side
);
    import ptd_pkg::*;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_ONE,
        MODE_FRAC,
        MODE_CLAMP
    } mode_t;

    localparam int XI [6] = '{1, 2, 1, 0, 0, 1};
    localparam int YI [6] = '{4, 3, 3, 4, 2, 1};

    logic [7:0] v_reg;

    geom_t geo1_reg, geo2_reg, geo3_reg, geo4_reg, geo5_reg, geo6_reg, geo7_reg;
    logic signed [PRW-1:0]  pr2_reg [15];
    logic signed [DOTW-1:0] dot3_reg [5];
    logic signed [DOTW-1:0] dot4_reg [5];
    logic signed [DOTW-1:0] dot5_reg [5];
    logic signed [DOTW-1:0] dot6_reg [5];
    logic [2*HW-1:0]        pp4_reg [6][4];
    logic                   sg4_reg [6];
    logic signed [WW-1:0]   prod5_reg [6];
    logic signed [WW-1:0]   s6_reg, t6_reg, det6_reg;

    mode_t                  mode7_reg [2];
    logic [WW-1:0]          num7_reg [2];
    logic [WW-1:0]          den7_reg [2];
    logic                   cs7_reg, ct7_reg;

    lane_t [1:0]            lanes8_reg;
    side_t                  side8_reg;

    function automatic logic signed [DW-1:0] sx(input logic [COORD_BITS-1:0] x);
        return $signed({x[COORD_BITS-1], x});
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[6:0], in_valid};
        end
    end

    // Stage 1: edges and offset.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                geo1_reg.e0[i] <= sx(in_data[(6+i)*COORD_BITS +: COORD_BITS])
                                - sx(in_data[(3+i)*COORD_BITS +: COORD_BITS]);
                geo1_reg.e1[i] <= sx(in_data[(9+i)*COORD_BITS +: COORD_BITS])
                                - sx(in_data[(3+i)*COORD_BITS +: COORD_BITS]);
                geo1_reg.dv[i] <= sx(in_data[(3+i)*COORD_BITS +: COORD_BITS])
                                - sx(in_data[i*COORD_BITS +: COORD_BITS]);
            end
        end
    end

    // Stage 2: component products, stage 3: dot products a to e.
    always_ff @(posedge aclk) begin
        if (en) begin
            geo2_reg <= geo1_reg;
            for (int i = 0; i < 3; i++) begin
                pr2_reg[i]      <= $signed(geo1_reg.e0[i]) * $signed(geo1_reg.e0[i]);
                pr2_reg[3 + i]  <= $signed(geo1_reg.e0[i]) * $signed(geo1_reg.e1[i]);
                pr2_reg[6 + i]  <= $signed(geo1_reg.e1[i]) * $signed(geo1_reg.e1[i]);
                pr2_reg[9 + i]  <= $signed(geo1_reg.e0[i]) * $signed(geo1_reg.dv[i]);
                pr2_reg[12 + i] <= $signed(geo1_reg.e1[i]) * $signed(geo1_reg.dv[i]);
            end
            geo3_reg <= geo2_reg;
            for (int k = 0; k < 5; k++) begin
                dot3_reg[k] <= DOTW'(pr2_reg[3*k]) + DOTW'(pr2_reg[3*k + 1])
                             + DOTW'(pr2_reg[3*k + 2]);
            end
        end
    end

    // Stage 4: partial products of the six wide products.
    logic [MW-1:0] mag_x [6];
    logic [MW-1:0] mag_y [6];

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            mag_x[j] = dot3_reg[XI[j]][DOTW-1] ? MW'(-dot3_reg[XI[j]]) : MW'(dot3_reg[XI[j]]);
            mag_y[j] = dot3_reg[YI[j]][DOTW-1] ? MW'(-dot3_reg[YI[j]]) : MW'(dot3_reg[YI[j]]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            geo4_reg <= geo3_reg;
            dot4_reg <= dot3_reg;
            for (int j = 0; j < 6; j++) begin
                sg4_reg[j]    <= dot3_reg[XI[j]][DOTW-1] ^ dot3_reg[YI[j]][DOTW-1];
                pp4_reg[j][0] <= mag_x[j][HW-1:0]  * mag_y[j][HW-1:0];
                pp4_reg[j][1] <= mag_x[j][HW-1:0]  * mag_y[j][MW-1:HW];
                pp4_reg[j][2] <= mag_x[j][MW-1:HW] * mag_y[j][HW-1:0];
                pp4_reg[j][3] <= mag_x[j][MW-1:HW] * mag_y[j][MW-1:HW];
            end
        end
    end

    // Stage 5: products, stage 6: s, t and det.
    logic [WW-1:0] mag_next [6];

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            mag_next[j] = (WW'(pp4_reg[j][3]) << (2*HW))
                        + ((WW'(pp4_reg[j][1]) + WW'(pp4_reg[j][2])) << HW)
                        + WW'(pp4_reg[j][0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            geo5_reg <= geo4_reg;
            dot5_reg <= dot4_reg;
            for (int j = 0; j < 6; j++) begin
                prod5_reg[j] <= sg4_reg[j] ? $signed(-mag_next[j]) : $signed(mag_next[j]);
            end
            geo6_reg <= geo5_reg;
            dot6_reg <= dot5_reg;
            s6_reg   <= prod5_reg[0] - prod5_reg[1];
            t6_reg   <= prod5_reg[2] - prod5_reg[3];
            det6_reg <= prod5_reg[4] - prod5_reg[5];
        end
    end

    // Stage 7: region choice.
    logic signed [WW-1:0] wa, wb, wc, wd, we, wbc;
    logic signed [WW-1:0] ms0, ms1, mt0, mt1, wr1;
    logic                 st_le;
    mode_t                mode_next [2];
    logic [WW-1:0]        num_next [2];
    logic [WW-1:0]        den_next [2];
    logic                 cs_next, ct_next;

    assign wa    = WW'(dot6_reg[0]);
    assign wb    = WW'(dot6_reg[1]);
    assign wc    = WW'(dot6_reg[2]);
    assign wd    = WW'(dot6_reg[3]);
    assign we    = WW'(dot6_reg[4]);
    assign wbc   = wa - wb - wb + wc;
    assign ms0   = wb + wd;
    assign ms1   = wc + we;
    assign mt0   = wb + we;
    assign mt1   = wa + wd;
    assign wr1   = ms1 - ms0;
    assign st_le = (s6_reg + t6_reg) <= det6_reg;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            mode_next[l] = MODE_ZERO;
            num_next[l]  = '0;
            den_next[l]  = '0;
        end
        cs_next = 1'b0;
        ct_next = 1'b0;
        if (st_le) begin
            if ((s6_reg < 0 && t6_reg < 0 && wd < 0) || (s6_reg >= 0 && t6_reg < 0)) begin
                mode_next[0] = (wd >= 0) ? MODE_ZERO : MODE_CLAMP;
                num_next[0]  = -wd;
                den_next[0]  = wa;
            end else if (s6_reg < 0) begin
                mode_next[1] = (we >= 0) ? MODE_ZERO : MODE_CLAMP;
                num_next[1]  = -we;
                den_next[1]  = wc;
            end else begin
                mode_next[0] = MODE_FRAC;
                num_next[0]  = s6_reg;
                den_next[0]  = det6_reg;
                mode_next[1] = MODE_FRAC;
                num_next[1]  = t6_reg;
                den_next[1]  = det6_reg;
            end
        end else if (s6_reg < 0) begin
            if (ms1 > ms0) begin
                mode_next[0] = MODE_CLAMP;
                num_next[0]  = wr1;
                den_next[0]  = wbc;
                ct_next      = 1'b1;
            end else if (ms1 <= 0) begin
                mode_next[1] = MODE_ONE;
            end else if (we < 0) begin
                mode_next[1] = MODE_FRAC;
                num_next[1]  = -we;
                den_next[1]  = wc;
            end
        end else if (t6_reg < 0) begin
            if (mt1 > mt0) begin
                mode_next[1] = MODE_CLAMP;
                num_next[1]  = mt1 - mt0;
                den_next[1]  = wbc;
                cs_next      = 1'b1;
            end else if (mt1 <= 0) begin
                mode_next[0] = MODE_ONE;
            end else if (wd < 0) begin
                mode_next[0] = MODE_FRAC;
                num_next[0]  = -wd;
                den_next[0]  = wa;
            end
        end else begin
            mode_next[0] = (wr1 <= 0) ? MODE_ZERO : MODE_CLAMP;
            num_next[0]  = wr1;
            den_next[0]  = wbc;
            ct_next      = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            geo7_reg  <= geo6_reg;
            mode7_reg <= mode_next;
            num7_reg  <= num_next;
            den7_reg  <= den_next;
            cs7_reg   <= cs_next;
            ct7_reg   <= ct_next;
        end
    end

    // Stage 8: trivial quotients and the zero divisor flag.
    lane_t [1:0] lanes_next;
    logic  [1:0] fl_next;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            lanes_next[l].num = num7_reg[l];
            lanes_next[l].den = den7_reg[l];
            lanes_next[l].sel = Q_ZERO;
            fl_next[l]        = 1'b0;
            unique case (mode7_reg[l])
                MODE_ZERO: begin
                    lanes_next[l].sel = Q_ZERO;
                end
                MODE_ONE: begin
                    lanes_next[l].sel = Q_ONE;
                end
                MODE_FRAC, MODE_CLAMP: begin
                    if (mode7_reg[l] == MODE_CLAMP &&
                        $signed(num7_reg[l]) >= $signed(den7_reg[l])) begin
                        lanes_next[l].sel = Q_ONE;
                    end else if ($signed(den7_reg[l]) <= 0) begin
                        fl_next[l] = 1'b1;
                    end else if ($signed(num7_reg[l]) <= 0) begin
                        lanes_next[l].sel = Q_ZERO;
                    end else if ($signed(num7_reg[l]) >= $signed(den7_reg[l])) begin
                        lanes_next[l].sel = Q_ONE;
                    end else begin
                        lanes_next[l].sel = Q_DIV;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lanes8_reg       <= lanes_next;
            side8_reg.geo    <= geo7_reg;
            side8_reg.comp_s <= cs7_reg;
            side8_reg.comp_t <= ct7_reg;
            side8_reg.flag   <= |fl_next;
        end
    end

    assign out_valid = v_reg[7];
    assign out_lanes = lanes8_reg;
    assign out_side  = side8_reg;

endmodule

[hw/rtl/ptd_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_div
// Two restoring fraction dividers, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module ptd_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  ptd_pkg::lane_t [1:0]              in_lanes,
    input  ptd_pkg::side_t                    in_side,
    output logic                              out_valid,
    output logic [1:0][ptd_pkg::QW-1:0]       out_q,
    output ptd_pkg::side_t                    out_side
);
    import ptd_pkg::*;

    localparam int NS = PAR_BITS;

    logic [NS-1:0]        v_reg;
    side_t                side_reg [NS];
    qsel_t                sel_reg  [2][NS];
    logic [WW:0]          rem_reg  [2][NS];
    logic [WW-1:0]        den_reg  [2][NS];
    logic [PAR_BITS-1:0]  q_reg    [2][NS];

    logic [WW:0]          src_rem  [2][NS];
    logic [WW-1:0]        src_den  [2][NS];
    logic [PAR_BITS-1:0]  src_q    [2][NS];
    qsel_t                src_sel  [2][NS];
    side_t                src_side [NS];
    logic [WW:0]          dbl      [2][NS];
    logic                 ge       [2][NS];

    always_comb begin
        src_side[0] = in_side;
        for (int l = 0; l < 2; l++) begin
            src_rem[l][0] = {1'b0, in_lanes[l].num};
            src_den[l][0] = in_lanes[l].den;
            src_q[l][0]   = '0;
            src_sel[l][0] = in_lanes[l].sel;
        end
        for (int k = 1; k < NS; k++) begin
            src_side[k] = side_reg[k-1];
            for (int l = 0; l < 2; l++) begin
                src_rem[l][k] = rem_reg[l][k-1];
                src_den[l][k] = den_reg[l][k-1];
                src_q[l][k]   = q_reg[l][k-1];
                src_sel[l][k] = sel_reg[l][k-1];
            end
        end
        for (int l = 0; l < 2; l++) begin
            for (int k = 0; k < NS; k++) begin
                dbl[l][k] = src_rem[l][k] << 1;
                ge[l][k]  = dbl[l][k] >= {1'b0, src_den[l][k]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NS; k++) begin
                side_reg[k] <= src_side[k];
                for (int l = 0; l < 2; l++) begin
                    rem_reg[l][k] <= ge[l][k] ? dbl[l][k] - {1'b0, src_den[l][k]}
                                              : dbl[l][k];
                    den_reg[l][k] <= src_den[l][k];
                    q_reg[l][k]   <= {src_q[l][k][PAR_BITS-2:0], ge[l][k]};
                    sel_reg[l][k] <= src_sel[l][k];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            unique case (sel_reg[l][NS-1])
                Q_ONE:   out_q[l] = PAR_ONE;
                Q_DIV:   out_q[l] = {1'b0, q_reg[l][NS-1]};
                default: out_q[l] = '0;
            endcase
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

[hw/rtl/ptd_dist.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_dist
// Closest point offset, squared length and pipelined integer square root.
// ----------------------------------------------------------------------------
module ptd_dist (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [1:0][ptd_pkg::QW-1:0]       in_q,
    input  ptd_pkg::side_t                    in_side,
    output logic                              out_valid,
    output logic [ptd_pkg::OUT_BITS-1:0]      out_distance,
    output logic                              out_degenerate
);
    import ptd_pkg::*;

    localparam int NR = ROOT_BITS;
    localparam int NV = 6 + NR + 1;

    logic [NV-1:0] v_reg;

    logic [QW-1:0]          sp1_reg, tp1_reg;
    geom_t                  geo1_reg;
    vec3_t                  dv2_reg;
    logic signed [VW-1:0]   ps2_reg [3];
    logic signed [VW-1:0]   pt2_reg [3];
    logic signed [VW-1:0]   v3_reg [3];
    logic [2*VHW-1:0]       ll4_reg [3];
    logic [2*VHW-1:0]       hl4_reg [3];
    logic [2*VHW-1:0]       hh4_reg [3];
    logic [SQW-1:0]         sqc5_reg [3];
    logic [2*NR-1:0]        y6_reg;
    logic                   fl_reg [6];

    logic [2*NR-1:0]        y_reg    [NR];
    logic [RMW-1:0]         rem_reg  [NR];
    logic [NR-1:0]          root_reg [NR];
    logic                   sfl_reg  [NR];

    logic [OUT_BITS-1:0]    dist_reg;
    logic                   degen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NV-2:0], in_valid};
        end
    end

    logic [VMW-1:0] mag [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = v3_reg[i][VW-1] ? VMW'(-v3_reg[i]) : VMW'(v3_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sp1_reg   <= in_side.comp_s ? PAR_ONE - in_q[1] : in_q[0];
            tp1_reg   <= in_side.comp_t ? PAR_ONE - in_q[0] : in_q[1];
            geo1_reg  <= in_side.geo;
            fl_reg[0] <= in_side.flag;

            dv2_reg <= geo1_reg.dv;
            for (int i = 0; i < 3; i++) begin
                ps2_reg[i] <= $signed({1'b0, sp1_reg}) * $signed(geo1_reg.e0[i]);
                pt2_reg[i] <= $signed({1'b0, tp1_reg}) * $signed(geo1_reg.e1[i]);
            end
            fl_reg[1] <= fl_reg[0];

            for (int i = 0; i < 3; i++) begin
                v3_reg[i] <= (VW'($signed(dv2_reg[i])) <<< PAR_BITS) + ps2_reg[i] + pt2_reg[i];
            end
            fl_reg[2] <= fl_reg[1];

            for (int i = 0; i < 3; i++) begin
                ll4_reg[i] <= mag[i][VHW-1:0]   * mag[i][VHW-1:0];
                hl4_reg[i] <= mag[i][VMW-1:VHW] * mag[i][VHW-1:0];
                hh4_reg[i] <= mag[i][VMW-1:VHW] * mag[i][VMW-1:VHW];
            end
            fl_reg[3] <= fl_reg[2];

            for (int i = 0; i < 3; i++) begin
                sqc5_reg[i] <= (SQW'(hh4_reg[i]) << (2*VHW))
                             + (SQW'(hl4_reg[i]) << (VHW + 1))
                             + SQW'(ll4_reg[i]);
            end
            fl_reg[4] <= fl_reg[3];

            y6_reg    <= (2*NR)'((sqc5_reg[0] + sqc5_reg[1] + sqc5_reg[2]) >> (2*PAR_BITS));
            fl_reg[5] <= fl_reg[4];
        end
    end

    logic [2*NR-1:0] src_y    [NR];
    logic [RMW-1:0]  src_rem  [NR];
    logic [NR-1:0]   src_root [NR];
    logic            src_fl   [NR];
    logic [RMW-1:0]  cur      [NR];
    logic [RMW-1:0]  trial    [NR];
    logic            ge       [NR];

    always_comb begin
        src_y[0]    = y6_reg;
        src_rem[0]  = '0;
        src_root[0] = '0;
        src_fl[0]   = fl_reg[5];
        for (int k = 1; k < NR; k++) begin
            src_y[k]    = y_reg[k-1];
            src_rem[k]  = rem_reg[k-1];
            src_root[k] = root_reg[k-1];
            src_fl[k]   = sfl_reg[k-1];
        end
        for (int k = 0; k < NR; k++) begin
            cur[k]   = {src_rem[k][RMW-3:0], src_y[k][2*NR-1 -: 2]};
            trial[k] = RMW'({src_root[k], 2'b01});
            ge[k]    = cur[k] >= trial[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NR; k++) begin
                y_reg[k]    <= src_y[k] << 2;
                rem_reg[k]  <= ge[k] ? cur[k] - trial[k] : cur[k];
                root_reg[k] <= {src_root[k][NR-2:0], ge[k]};
                sfl_reg[k]  <= src_fl[k];
            end
            dist_reg  <= (|root_reg[NR-1][NR-1:OUT_BITS]) ? {OUT_BITS{1'b1}}
                                                          : root_reg[NR-1][OUT_BITS-1:0];
            degen_reg <= sfl_reg[NR-1];
        end
    end

    assign out_valid      = v_reg[NV-1];
    assign out_distance   = dist_reg;
    assign out_degenerate = degen_reg;

endmodule

[hw/rtl/point_triangle_distance.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_triangle_distance
// Distance from a query point to a triangle, pipelined fixed point datapath.
// ----------------------------------------------------------------------------
// The input item on s_tdata holds twelve signed Q11.12 coordinates of 24 bits
// each: point x, y, z, then vertex A, B and C, each x, y, z, from bit 0 up.
// The result item on m_tdata holds the distance as unsigned Q13.12 in bits
// 24:0, saturating, and in bit 25 a flag that marks a degenerate triangle.
// Every item gives exactly one result, in order.
// The pipeline takes one item in every cycle while it is not held. It runs
// through the dot products, the wide products and the region choice, then
// the two fraction dividers at one quotient bit per stage, then the squared
// distance, a 27 stage square root and the output register.
// A synchronous low aresetn clears all valid bits; results in flight are
// dropped. While m_tvalid is high and m_tready low the whole pipeline holds
// and s_tready is low, so no item is lost or repeated.
// ----------------------------------------------------------------------------
module point_triangle_distance (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // point_x, point_y, point_z, vertex_a_x .. vertex_c_z, 24 bits each
    input  logic [ptd_pkg::IN_TDW-1:0]        s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // distance_out [24:0], degenerate [25], zero fill above
    output logic [ptd_pkg::OUT_TDW-1:0]       m_tdata
);
    import ptd_pkg::*;

    logic                en;
    logic                f_valid, d_valid;
    lane_t [1:0]         f_lanes;
    side_t               f_side, d_side;
    logic [1:0][QW-1:0]  d_q;
    logic [OUT_BITS-1:0] distance;
    logic                degenerate;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    ptd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (f_valid),
        .out_lanes (f_lanes),
        .out_side  (f_side)
    );

    ptd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_lanes  (f_lanes),
        .in_side   (f_side),
        .out_valid (d_valid),
        .out_q     (d_q),
        .out_side  (d_side)
    );

    ptd_dist u_dist (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_valid       (d_valid),
        .in_q           (d_q),
        .in_side        (d_side),
        .out_valid      (m_tvalid),
        .out_distance   (distance),
        .out_degenerate (degenerate)
    );

    assign m_tdata = {{(OUT_TDW - OUT_BITS - 1){1'b0}}, degenerate, distance};

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the point to triangle distance pipeline.
// ----------------------------------------------------------------------------
// Items of twelve coordinates are streamed into the block and every result is
// compared with an exact wide-integer prediction of the distance and of the
// degenerate flag. Directed cases cover the seven regions, degenerate
// triangles and field extremes. Random cases mix full-range and near-field
// geometry under three idling patterns, plus a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import ptd_pkg::*;

    typedef logic signed [255:0] wide_t;
    typedef int coords_t [12];

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_TDW-1:0]    s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_TDW-1:0]   m_tdata;

    logic [25:0] expected_results [$];
    int          mismatch_count;
    int          src_idle_pct;
    int          snk_idle_pct;
    int          hold_cycles;

    point_triangle_distance DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic wide_t sext24(logic [23:0] v);
        return wide_t'(signed'(v));
    endfunction

    function automatic wide_t unit_param();
        wide_t one;
        one = 1;
        return one << PAR_BITS;
    endfunction

    function automatic wide_t ratio_param(wide_t num, wide_t den, inout bit flag);
        if (den <= 0) begin
            flag = 1'b1;
            return 0;
        end
        if (num <= 0) return 0;
        if (num >= den) return unit_param();
        return (num << PAR_BITS) / den;
    endfunction

    function automatic wide_t edge_param(wide_t g, wide_t len, inout bit flag);
        if (g >= 0) return 0;
        if (-g >= len) return unit_param();
        return ratio_param(-g, len, flag);
    endfunction

    function automatic wide_t clamped_param(wide_t num, wide_t den, inout bit flag);
        if (num >= den) return unit_param();
        return ratio_param(num, den, flag);
    endfunction

    // Returns {degenerate, distance}.
    function automatic logic [25:0] predict_distance(logic [IN_TDW-1:0] d);
        wide_t e0 [3];
        wide_t e1 [3];
        wide_t dv [3];
        wide_t a, b, c, dd, e, s, t, det, bc, m0, m1, num, sp, tp, one, v, sq, y, r, cand;
        bit flag;
        one = unit_param();
        flag = 1'b0;
        for (int i = 0; i < 3; i++) begin
            dv[i] = sext24(d[(3+i)*24 +: 24]) - sext24(d[i*24 +: 24]);
            e0[i] = sext24(d[(6+i)*24 +: 24]) - sext24(d[(3+i)*24 +: 24]);
            e1[i] = sext24(d[(9+i)*24 +: 24]) - sext24(d[(3+i)*24 +: 24]);
        end
        a  = e0[0]*e0[0] + e0[1]*e0[1] + e0[2]*e0[2];
        b  = e0[0]*e1[0] + e0[1]*e1[1] + e0[2]*e1[2];
        c  = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
        dd = e0[0]*dv[0] + e0[1]*dv[1] + e0[2]*dv[2];
        e  = e1[0]*dv[0] + e1[1]*dv[1] + e1[2]*dv[2];
        s   = b*e - c*dd;
        t   = b*dd - a*e;
        det = a*c - b*b;
        bc  = a - 2*b + c;
        if (s + t <= det) begin
            if (s < 0) begin
                if (t < 0 && dd < 0) begin
                    tp = 0;
                    sp = edge_param(dd, a, flag);
                end else begin
                    sp = 0;
                    tp = edge_param(e, c, flag);
                end
            end else if (t < 0) begin
                tp = 0;
                sp = edge_param(dd, a, flag);
            end else begin
                sp = ratio_param(s, det, flag);
                tp = ratio_param(t, det, flag);
            end
        end else if (s < 0) begin
            m0 = b + dd;
            m1 = c + e;
            if (m1 > m0) begin
                sp = clamped_param(m1 - m0, bc, flag);
                tp = one - sp;
            end else begin
                sp = 0;
                if (m1 <= 0) tp = one;
                else if (e >= 0) tp = 0;
                else tp = ratio_param(-e, c, flag);
            end
        end else if (t < 0) begin
            m0 = b + e;
            m1 = a + dd;
            if (m1 > m0) begin
                tp = clamped_param(m1 - m0, bc, flag);
                sp = one - tp;
            end else begin
                tp = 0;
                if (m1 <= 0) sp = one;
                else if (dd >= 0) sp = 0;
                else sp = ratio_param(-dd, a, flag);
            end
        end else begin
            num = (c + e) - (b + dd);
            if (num <= 0) sp = 0;
            else sp = clamped_param(num, bc, flag);
            tp = one - sp;
        end
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            v = dv[i]*one + sp*e0[i] + tp*e1[i];
            sq = sq + v*v;
        end
        y = sq >>> (2*PAR_BITS);
        r = 0;
        for (int k = 40; k >= 0; k--) begin
            cand = r | (wide_t'(1) << k);
            if (cand*cand <= y) r = cand;
        end
        if (r > 33554431) r = 33554431;
        return {flag, r[24:0]};
    endfunction

    function automatic logic [IN_TDW-1:0] pack_item(coords_t v);
        logic [IN_TDW-1:0] d;
        for (int i = 0; i < 12; i++) d[i*24 +: 24] = v[i][23:0];
        return d;
    endfunction

    function automatic int near_coord(int span);
        return int'($urandom_range(2*span)) - span;
    endfunction

    task automatic send_item(coords_t v);
        logic [IN_TDW-1:0] d;
        d = pack_item(v);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = d;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_distance(d));
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
    endtask

    task automatic test_regions();
        int u;
        u = 4096;
        // Triangle in the z = 0 plane, A at origin, B on x, C on y.
        send_item('{u/4, u/4, u/8, 0, 0, 0, 10*u, 0, 0, 0, 10*u, 0});
        send_item('{-u, -u, 0, 0, 0, 0, 10*u, 0, 0, 0, 10*u, 0});
        send_item('{15*u, -u, 3*u, 0, 0, 0, 10*u, 0, 0, 0, 10*u, 0});
        send_item('{-u, 15*u, -u, 0, 0, 0, 10*u, 0, 0, 0, 10*u, 0});
        send_item('{5*u, -2*u, 0, 0, 0, 0, 10*u, 0, 0, 0, 10*u, 0});
        send_item('{-2*u, 5*u, u, 0, 0, 0, 10*u, 0, 0, 0, 10*u, 0});
        send_item('{8*u, 8*u, 0, 0, 0, 0, 10*u, 0, 0, 0, 10*u, 0});
        send_item('{3*u, 3*u, 0, 0, 0, 0, 10*u, 0, 0, 0, 10*u, 0});
        wait_drained();
    endtask

    task automatic test_degenerate();
        int u;
        u = 4096;
        send_item('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        send_item('{u, 2*u, 3*u, 5, 5, 5, 5, 5, 5, 5, 5, 5});
        // Collinear vertices, point beside and beyond the segment.
        send_item('{u, u, 0, 0, 0, 0, 2*u, 0, 0, 4*u, 0, 0});
        send_item('{9*u, 0, 0, 0, 0, 0, 2*u, 0, 0, 4*u, 0, 0});
        send_item('{-3*u, 0, u, 0, 0, 0, 2*u, 0, 0, 4*u, 0, 0});
        // Two coincident vertices.
        send_item('{u, u, u, 0, 0, 0, 3*u, 3*u, 0, 3*u, 3*u, 0});
        send_item('{u, u, u, 3*u, 3*u, 0, 0, 0, 0, 3*u, 3*u, 0});
        wait_drained();
    endtask

    task automatic test_extremes();
        int mx, mn;
        mx = 8388607;
        mn = -8388608;
        send_item('{mn, mn, mn, mx, mx, mx, mx, mn, mx, mn, mx, mx});
        send_item('{mx, mx, mx, mn, mn, mn, mn, mx, mn, mx, mn, mn});
        send_item('{mn, mx, mn, mx, mx, mx, mx, mx, mx, mx, mx, mx});
        send_item('{-1, -1, -1, mn, mn, mn, mx, mx, mx, mn, mx, 0});
        send_item('{0, 0, 0, mx, 0, 0, 0, mx, 0, 0, 0, mx});
        send_item('{mx, mx, mx, mn, 0, 0, 0, mn, 0, 0, 0, mn});
        send_item('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1});
        wait_drained();
    endtask

    task automatic send_random(int count);
        coords_t v;
        int kind, span, ctr;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(9);
            span = (kind < 5) ? 8000 : 200000;
            ctr  = near_coord(4000000);
            for (int i = 0; i < 12; i++) begin
                if (kind >= 8) v[i] = int'($urandom());
                else v[i] = ctr + near_coord(span);
            end
            // Collinear or coincident vertices now and then.
            if (kind == 7) begin
                for (int i = 0; i < 3; i++) v[9+i] = 2*v[6+i] - v[3+i];
            end else if (kind == 6) begin
                for (int i = 0; i < 3; i++) v[6+i] = v[3+i];
            end
            send_item(v);
        end
        wait_drained();
    endtask

    task automatic test_random_phases();
        src_idle_pct = 21;
        snk_idle_pct = 71;
        send_random(300);
        src_idle_pct = 71;
        snk_idle_pct = 21;
        send_random(300);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_random(300);
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_cycles  = 400;
        send_random(200);
    endtask

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge aclk) begin
        logic [25:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result item %h", m_tdata);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[24:0] !== want[24:0] || m_tdata[25] !== want[25]
                        || m_tdata[OUT_TDW-1:26] !== '0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected distance %0d degenerate %0d, got %0d %0d",
                                 want[24:0], want[25], m_tdata[24:0], m_tdata[25]);
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("FAIL");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        mismatch_count = 0;
        src_idle_pct   = 0;
        snk_idle_pct   = 0;
        hold_cycles    = 0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        test_regions();
        test_degenerate();
        test_extremes();
        test_random_phases();
        test_backpressure();
        repeat (200) @(negedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
